>>> sv/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int DIM_BITS       = 13;
    localparam int COLOR_BITS     = 24;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [DIM_BITS-1:0]   WIDTH_RST  = 13'd640;
    localparam logic [DIM_BITS-1:0]   HEIGHT_RST = 13'd480;
    localparam logic [COLOR_BITS-1:0] COLOR_RST  = 24'hFF_FFFF;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_TARGET_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_TARGET_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_DRAW_COLOR    = 2'd2;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } t_req;

    typedef struct packed {
        logic [DIM_BITS-1:0]   target_width;
        logic [DIM_BITS-1:0]   target_height;
        logic [COLOR_BITS-1:0] draw_color;
    } t_cfg;

    // Per-point flags from the stepping core
    typedef struct packed {
        logic emit;
        logic in_bounds;
        logic last;
    } t_pt_flags;

endpackage

>>> sv/bls_cfg_regs.sv
// ----------------------------------------------------------------------------
// bls_cfg_regs
// Configuration register bank: target size and draw colour.
// ----------------------------------------------------------------------------
module bls_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  bls_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [bls_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output bls_pkg::t_cfg                       o_cfg
);
    import bls_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_width  <= WIDTH_RST;
            r_cfg.target_height <= HEIGHT_RST;
            r_cfg.draw_color    <= COLOR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET_WIDTH:  r_cfg.target_width  <= i_cfg_data[DIM_BITS-1:0];
                CFG_TARGET_HEIGHT: r_cfg.target_height <= i_cfg_data[DIM_BITS-1:0];
                CFG_DRAW_COLOR:    r_cfg.draw_color    <= i_cfg_data[COLOR_BITS-1:0];
                default: ; // unused index, ignored
            endcase
        end
    end

endmodule

>>> sv/bls_line_core.sv
// ----------------------------------------------------------------------------
// bls_line_core
// Line state registers and the one-point Bresenham update.
// ----------------------------------------------------------------------------
module bls_line_core #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  bls_pkg::t_req                  i_req,
    input  logic signed [COORD_BITS-1:0]   i_x_start,
    input  logic signed [COORD_BITS-1:0]   i_y_start,
    input  logic signed [COORD_BITS-1:0]   i_x_stop,
    input  logic signed [COORD_BITS-1:0]   i_y_stop,
    input  bls_pkg::t_cfg                  i_cfg,
    output logic signed [COORD_BITS-1:0]   o_px,
    output logic signed [COORD_BITS-1:0]   o_py,
    output bls_pkg::t_pt_flags             o_flags
);
    import bls_pkg::*;

    localparam int EB = COORD_BITS + 2;   // error term
    localparam int DB = COORD_BITS + 1;   // signed differences
    localparam int CB = COORD_BITS + DIM_BITS;

    logic signed [COORD_BITS-1:0] r_cur_x, r_cur_y, r_goal_x, r_goal_y;
    logic signed [COORD_BITS-1:0] n_cur_x, n_cur_y, n_goal_x, n_goal_y;
    logic        [COORD_BITS-1:0] r_dx, r_dy, n_dx, n_dy;
    logic                         r_xneg, r_yneg, n_xneg, n_yneg;
    logic signed [EB-1:0]         r_err, n_err;
    logic                         r_busy, n_busy;

    logic signed [DB-1:0]         diff_x, diff_y;
    logic        [COORD_BITS-1:0] abs_x, abs_y;
    logic signed [EB:0]           e2, neg_dy, pos_dx;
    logic                         mv_x, mv_y, last, inb;

    // start: deltas and directions
    always_comb begin
        diff_x = DB'(i_x_stop) - DB'(i_x_start);
        diff_y = DB'(i_y_stop) - DB'(i_y_start);
        abs_x  = diff_x[DB-1] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
        abs_y  = diff_y[DB-1] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    end

    // step: error rule
    always_comb begin
        e2     = {r_err, 1'b0};
        neg_dy = -$signed({3'b000, r_dy});
        pos_dx = $signed({3'b000, r_dx});
        mv_x   = e2 > neg_dy;
        mv_y   = e2 < pos_dx;
    end

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_goal_x = r_goal_x;
        n_goal_y = r_goal_y;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_xneg   = r_xneg;
        n_yneg   = r_yneg;
        n_err    = r_err;
        unique case (i_req)
            REQ_START: begin
                n_cur_x  = i_x_start;
                n_cur_y  = i_y_start;
                n_goal_x = i_x_stop;
                n_goal_y = i_y_stop;
                n_dx     = abs_x;
                n_dy     = abs_y;
                n_xneg   = !(i_x_start < i_x_stop);
                n_yneg   = !(i_y_start < i_y_stop);
                n_err    = $signed({2'b00, abs_x}) - $signed({2'b00, abs_y});
            end
            REQ_STEP: begin
                n_err = r_err - (mv_x ? $signed({2'b00, r_dy}) : EB'(0))
                              + (mv_y ? $signed({2'b00, r_dx}) : EB'(0));
                if (mv_x) begin
                    n_cur_x = r_xneg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                end
                if (mv_y) begin
                    n_cur_y = r_yneg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // point checks on the point being emitted
    always_comb begin
        last = (n_cur_x == n_goal_x) && (n_cur_y == n_goal_y);
        inb  = !n_cur_x[COORD_BITS-1] && !n_cur_y[COORD_BITS-1]
            && (CB'($unsigned(n_cur_x)) < CB'(i_cfg.target_width))
            && (CB'($unsigned(n_cur_y)) < CB'(i_cfg.target_height));
        n_busy = !last;
    end

    assign o_px            = n_cur_x;
    assign o_py            = n_cur_y;
    assign o_flags.emit    = (i_req == REQ_START) || r_busy;
    assign o_flags.in_bounds = inb;
    assign o_flags.last    = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_xneg   <= 1'b0;
            r_yneg   <= 1'b0;
            r_err    <= '0;
            r_busy   <= 1'b0;
        end else if (i_fire && o_flags.emit) begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_goal_x <= n_goal_x;
            r_goal_y <= n_goal_y;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_xneg   <= n_xneg;
            r_yneg   <= n_yneg;
            r_err    <= n_err;
            r_busy   <= n_busy;
        end
    end

endmodule

>>> sv/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// All-octant Bresenham line stepper with bounds flag, colour and end marker.
// ----------------------------------------------------------------------------
// A result is registered and presented in the cycle after its input transfer.
// Throughput: one item per cycle unless the pixel stream stalls; the single error
// update plus the point checks sit between the line state registers and the output register.
// Reset (synchronous, active low): line idle, no result pending, target
// 640 x 480, colour 0xFFFFFF.
module bresenham_line_stepper #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    // request stream
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata: x_start, y_start, x_stop, y_stop (COORD_BITS each), zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    // tuser: req_type (0 start, 1 step)
    input  logic                                   i_s_axis_tuser,

    // pixel stream
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // tdata: pixel_x, pixel_y (COORD_BITS each), pixel_color (24), zero pad
    output logic [((2*COORD_BITS+24+7)/8)*8-1:0]   o_m_axis_tdata,
    // tuser: in_bounds
    output logic                                   o_m_axis_tuser,
    output logic                                   o_m_axis_tlast,

    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  bls_pkg::t_cfg_idx                      i_cfg_index,
    input  logic [bls_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);
    import bls_pkg::*;

    localparam int OUT_BITS = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;
    localparam int OUT_USED = 2*COORD_BITS + COLOR_BITS;

    t_cfg                         cfg;
    t_pt_flags                    flags;
    logic signed [COORD_BITS-1:0] px, py;
    logic signed [COORD_BITS-1:0] x_start, y_start, x_stop, y_stop;
    logic                         fire;

    // output register
    logic                         r_out_valid;
    logic [OUT_USED-1:0]          r_out_data;
    logic                         r_out_inb, r_out_last;

    // unpack request fields, lowest first
    assign x_start = i_s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    assign y_start = i_s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    assign x_stop  = i_s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    assign y_stop  = i_s_axis_tdata[3*COORD_BITS +: COORD_BITS];

    // Take a request whenever the output register is empty or being drained
    // in the same cycle; this keeps one point per cycle under full flow.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign fire            = i_s_axis_tvalid && o_s_axis_tready;

    bls_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bls_line_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_req     (t_req'(i_s_axis_tuser)),
        .i_x_start (x_start),
        .i_y_start (y_start),
        .i_x_stop  (x_stop),
        .i_y_stop  (y_stop),
        .i_cfg     (cfg),
        .o_px      (px),
        .o_py      (py),
        .o_flags   (flags)
    );

    // Valid: set by a transfer that emits a point, cleared once taken.
    // A step while idle is accepted but produces nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= flags.emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: colour is sampled at emission time.
    always_ff @(posedge i_clk) begin
        if (fire && flags.emit) begin
            r_out_data <= {cfg.draw_color, py, px};
            r_out_inb  <= flags.in_bounds;
            r_out_last <= flags.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_BITS-OUT_USED){1'b0}}, r_out_data};
    assign o_m_axis_tuser  = r_out_inb;
    assign o_m_axis_tlast  = r_out_last;

endmodule
